// ===== design/assert_macros.svh =====
// Assertion helpers for the design files; only the top module includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General form: label, clock, active-low reset and the property.
`define RODR_ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rodr assertion failed");

// Short form for modules that use the usual clock and reset names.
`define RODR_ASSERT(lbl, prop) \
    `RODR_ASSERT_CLK(lbl, i_clk, i_rst_n, prop)

`endif

// ===== design/rodr_pkg.sv =====
package rodr_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int ROT_W        = 32;
    localparam int ENTRY_W      = 32;
    localparam int CORDIC_STEPS = 28;
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int SQRT_CELLS   = 32;
    localparam int DIV_CELLS    = 31;

    localparam logic signed [63:0] ONE60      = 64'sd1 <<< 60;
    localparam logic signed [63:0] PI60       = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] HALF_PI60  = PI60 >>> 1;
    localparam logic signed [63:0] TWO_PI60   = PI60 <<< 1;
    localparam logic signed [63:0] PI_HALF3   = PI60 + HALF_PI60;
    localparam logic [63:0]        FOUR_PI60U = {TWO_PI60[62:0], 1'b0};
    localparam logic signed [31:0] ONE30      = 32'sh4000_0000;
    localparam logic signed [63:0] HALF_LSB30 = 64'sd1 <<< 29;

    typedef logic signed [63:0] t_angle_tab [CORDIC_STEPS];

    // Square root cell: partial remainder, root so far, radicand left to scan.
    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } t_sqrt;

    // Division cell: partial remainder, divisor, quotient so far.
    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] dvsr;
        logic [30:0] quo;
    } t_div;

    // Rotation cell: cosine, sine and residual angle, all Q.60.
    typedef struct packed {
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] z;
    } t_rot;

    // What the matrix stages receive from the axis and angle paths.
    typedef struct packed {
        logic [2:0]         neg;
        logic               flip;
        logic               zero;
        logic [30:0]        q0;
        logic [30:0]        q1;
        logic [30:0]        q2;
        logic signed [63:0] x;
        logic signed [63:0] y;
    } t_mx_in;

    // atan(2^-i) in Q.60 from its power series.
    function automatic logic signed [63:0] atan_q60(input int i);
        logic signed [63:0] s;
        logic [63:0]        term;
        int                 k;
        s = '0;
        if (i == 0) begin
            s = PI60 >>> 2;
        end else begin
            for (k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = ((64'd1 << 60) >> (i * (2 * k + 1))) / 64'(2 * k + 1);
                s = k[0] ? s - signed'(term) : s + signed'(term);
            end
        end
        return s;
    endfunction

    function automatic t_angle_tab build_angles();
        t_angle_tab t;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            t[i] = atan_q60(i);
        end
        return t;
    endfunction

    // Inverse of the rotation gain: vector (1,0) for the gain, then 1/gain.
    function automatic logic signed [63:0] inv_gain_q60();
        logic signed [63:0] x;
        logic signed [63:0] y;
        logic signed [63:0] nx;
        logic signed [63:0] ny;
        logic [63:0]        r;
        logic [63:0]        q;
        logic [63:0]        g;
        x = ONE60;
        y = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
            end
            x = nx;
            y = ny;
        end
        g = unsigned'(x);
        r = 64'd1 << 60;
        q = '0;
        for (int i = 0; i < 60; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r = r - g;
                q = q | 64'd1;
            end
        end
        return signed'(q);
    endfunction

    localparam t_angle_tab         ANGLE_TAB = build_angles();
    localparam logic signed [63:0] INV_GAIN  = inv_gain_q60();

    // Round a Q.60 value to Q.30: add half, floor.
    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        return (v + HALF_LSB30) >>> 30;
    endfunction

    function automatic logic signed [31:0] clamp30(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'(ONE30)) begin
            r = ONE30;
        end else if (v < -64'(ONE30)) begin
            r = -ONE30;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/rodr_in_if.sv =====
interface rodr_in_if;
    import rodr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] pos_x;
    logic signed [DATA_WIDTH-1:0] pos_y;
    logic signed [DATA_WIDTH-1:0] pos_z;
    logic signed [ROT_W-1:0]      rotvec_x;
    logic signed [ROT_W-1:0]      rotvec_y;
    logic signed [ROT_W-1:0]      rotvec_z;

    modport source (output valid, pos_x, pos_y, pos_z, rotvec_x, rotvec_y, rotvec_z,
                    input ready);
    modport sink (input valid, pos_x, pos_y, pos_z, rotvec_x, rotvec_y, rotvec_z,
                  output ready);
endinterface

// ===== design/rodr_out_if.sv =====
interface rodr_out_if;
    import rodr_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [ENTRY_W-1:0]    m00;
    logic signed [ENTRY_W-1:0]    m01;
    logic signed [ENTRY_W-1:0]    m02;
    logic signed [ENTRY_W-1:0]    m10;
    logic signed [ENTRY_W-1:0]    m11;
    logic signed [ENTRY_W-1:0]    m12;
    logic signed [ENTRY_W-1:0]    m20;
    logic signed [ENTRY_W-1:0]    m21;
    logic signed [ENTRY_W-1:0]    m22;
    logic signed [DATA_WIDTH-1:0] out_x;
    logic signed [DATA_WIDTH-1:0] out_y;
    logic signed [DATA_WIDTH-1:0] out_z;

    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    out_x, out_y, out_z, input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  out_x, out_y, out_z, output ready);
endinterface

// ===== design/rodr_sqrt_cell.sv =====
module rodr_sqrt_cell (
    input  logic            i_clk,
    input  logic            i_en,
    input  rodr_pkg::t_sqrt i_d,
    output rodr_pkg::t_sqrt o_d
);
    import rodr_pkg::*;

    t_sqrt       r_d;
    logic [35:0] w;
    logic [35:0] trial;
    logic        ge;

    // Bring down two radicand bits and try the next root bit.
    assign w     = {i_d.rem, i_d.rad[63:62]};
    assign trial = {2'b00, i_d.root, 2'b01};
    assign ge    = (w >= trial);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.rem  <= ge ? 34'(w - trial) : w[33:0];
            r_d.root <= {i_d.root[30:0], ge};
            r_d.rad  <= {i_d.rad[61:0], 2'b00};
        end
    end

    assign o_d = r_d;
endmodule

// ===== design/rodr_div_cell.sv =====
module rodr_div_cell (
    input  logic           i_clk,
    input  logic           i_en,
    input  rodr_pkg::t_div i_d,
    output rodr_pkg::t_div o_d
);
    import rodr_pkg::*;

    t_div        r_d;
    logic        ge;
    logic [32:0] diff;

    // One quotient bit per cell; the remainder stays below twice the divisor.
    assign ge   = (i_d.rem >= {1'b0, i_d.dvsr});
    assign diff = ge ? (i_d.rem - {1'b0, i_d.dvsr}) : i_d.rem;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d.rem  <= {diff[31:0], 1'b0};
            r_d.dvsr <= i_d.dvsr;
            r_d.quo  <= {i_d.quo[29:0], ge};
        end
    end

    assign o_d = r_d;
endmodule

// ===== design/rodr_cordic_cell.sv =====
module rodr_cordic_cell (
    input  logic              i_clk,
    input  logic              i_en,
    input  logic [rodr_pkg::STEP_W-1:0] i_step,
    input  rodr_pkg::t_rot    i_d,
    output rodr_pkg::t_rot    o_d
);
    import rodr_pkg::*;

    t_rot               r_d;
    logic signed [63:0] xs;
    logic signed [63:0] ys;
    logic signed [63:0] ang;

    // The step input is tied off per cell, so the shifts fold to wiring.
    assign xs  = i_d.x >>> i_step;
    assign ys  = i_d.y >>> i_step;
    assign ang = ANGLE_TAB[i_step];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_d.z[63]) begin
                r_d.x <= i_d.x - ys;
                r_d.y <= i_d.y + xs;
                r_d.z <= i_d.z - ang;
            end else begin
                r_d.x <= i_d.x + ys;
                r_d.y <= i_d.y - xs;
                r_d.z <= i_d.z + ang;
            end
        end
    end

    assign o_d = r_d;
endmodule

// ===== design/rodr_matrix.sv =====
module rodr_matrix (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  rodr_pkg::t_mx_in              i_d,
    output logic signed [rodr_pkg::ENTRY_W-1:0] o_m [9]
);
    import rodr_pkg::*;

    localparam int PA [6] = '{0, 1, 2, 0, 0, 1};
    localparam int PB [6] = '{0, 1, 2, 1, 2, 2};

    // First stage: signed axis, rounded and clamped cosine and sine.
    logic signed [31:0] k_in [3];
    logic signed [63:0] xf;
    logic signed [63:0] yf;
    logic signed [31:0] r_k1 [3];
    logic signed [31:0] r_c1;
    logic signed [31:0] r_s1;
    logic               r_z1;
    // Second stage: axis outer products and 1 - c.
    logic signed [63:0] r_kk [6];
    logic signed [31:0] r_k2 [3];
    logic signed [31:0] r_c2;
    logic signed [31:0] r_s2;
    logic signed [32:0] r_t2;
    logic               r_z2;
    // Third stage: products scaled by 1 - c and by s.
    logic signed [63:0] r_pt [6];
    logic signed [63:0] r_sk [3];
    logic signed [31:0] r_c3;
    logic               r_z3;
    logic signed [31:0] rk [6];
    // Fourth stage: entry sums.
    logic signed [63:0] cterm;
    logic signed [63:0] acc [9];
    logic signed [31:0] r_m [9];

    assign k_in[0] = i_d.neg[0] ? -$signed({1'b0, i_d.q0}) : $signed({1'b0, i_d.q0});
    assign k_in[1] = i_d.neg[1] ? -$signed({1'b0, i_d.q1}) : $signed({1'b0, i_d.q1});
    assign k_in[2] = i_d.neg[2] ? -$signed({1'b0, i_d.q2}) : $signed({1'b0, i_d.q2});
    assign xf = i_d.flip ? -i_d.x : i_d.x;
    assign yf = i_d.flip ? -i_d.y : i_d.y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k1 <= k_in;
            r_c1 <= clamp30(rnd30(xf));
            r_s1 <= clamp30(rnd30(yf));
            r_z1 <= i_d.zero;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < 6; p++) begin
                r_kk[p] <= 64'(r_k1[PA[p]]) * 64'(r_k1[PB[p]]);
            end
            r_k2 <= r_k1;
            r_c2 <= r_c1;
            r_s2 <= r_s1;
            r_t2 <= 33'(ONE30) - 33'(r_c1);
            r_z2 <= r_z1;
        end
    end

    always_comb begin
        for (int p = 0; p < 6; p++) begin
            rk[p] = 32'(rnd30(r_kk[p]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int p = 0; p < 6; p++) begin
                r_pt[p] <= 64'(rk[p]) * 64'(r_t2);
            end
            for (int l = 0; l < 3; l++) begin
                r_sk[l] <= 64'(r_s2) * 64'(r_k2[l]);
            end
            r_c3 <= r_c2;
            r_z3 <= r_z2;
        end
    end

    // Rodrigues: c on the diagonal, the cross-product matrix scaled by s
    // off it, and the outer product scaled by 1 - c everywhere.
    assign cterm  = 64'(r_c3) <<< 30;
    assign acc[0] = r_pt[0] + cterm;
    assign acc[1] = r_pt[3] - r_sk[2];
    assign acc[2] = r_pt[4] + r_sk[1];
    assign acc[3] = r_pt[3] + r_sk[2];
    assign acc[4] = r_pt[1] + cterm;
    assign acc[5] = r_pt[5] - r_sk[0];
    assign acc[6] = r_pt[4] - r_sk[1];
    assign acc[7] = r_pt[5] + r_sk[0];
    assign acc[8] = r_pt[2] + cterm;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int e = 0; e < 9; e++) begin
                if (r_z3) begin
                    r_m[e] <= (e % 4 == 0) ? ONE30 : '0;
                end else begin
                    r_m[e] <= clamp30(rnd30(acc[e]));
                end
            end
        end
    end

    assign o_m = r_m;
endmodule

// ===== design/pose_to_homogeneous_transform.sv =====
// Channel   Dir  Beat contents
// i_pose    in   pos_x/y/z translation, rotvec_x/y/z rotation vector (Q3.28)
// o_xform   out  m00..m22 rotation entries (Q1.30), out_x/y/z translation
//
// One beat is accepted every clock while the skid entry is free; a beat's
// result goes through 2 square-and-sum stages, 32 square root cells, 31 axis
// division cells run alongside the 2 angle reduction, 1 quadrant and 28
// rotation cells, then 4 matrix stages. Reset clears only valid bits,
// the skid entry's included. When o_xform stalls, one more beat moves into
// the skid entry, after which the whole row of cells holds until it is taken.
`include "assert_macros.svh"

module pose_to_homogeneous_transform (
    input logic        i_clk,
    input logic        i_rst_n,
    rodr_in_if.sink    i_pose,
    rodr_out_if.source o_xform
);
    import rodr_pkg::*;

    // Stage numbering: stage s is the s-th register bank after acceptance.
    // Theta is ready at S_TH; the axis and angle branches meet at S_BR; the
    // matrix result sits in the last stage.
    localparam int S_TH    = 2 + SQRT_CELLS;
    localparam int ANG_LAT = CORDIC_STEPS + 3;
    localparam int BR      = (ANG_LAT > DIV_CELLS) ? ANG_LAT : DIV_CELLS;
    localparam int DIV_PAD = BR - DIV_CELLS;
    localparam int ANG_PAD = BR - ANG_LAT;
    localparam int S_BR    = S_TH + BR;
    localparam int LAT     = S_BR + 4;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] x;
        logic signed [DATA_WIDTH-1:0] y;
        logic signed [DATA_WIDTH-1:0] z;
        logic [2:0]                   neg;
    } t_side;

    logic                      en;
    logic                      r_vld [1:LAT];
    t_side                     r_side [1:LAT];
    logic [2:0][31:0]          r_mag [1:S_TH];
    logic [2:0][63:0]          r_sq;
    logic [63:0]               r_sum;
    logic [2:0][31:0]          mag_in;
    logic [2:0]                neg_in;
    logic signed [ROT_W-1:0]   rv [3];

    t_sqrt                     sq_c [SQRT_CELLS+1];
    logic [31:0]               theta;
    t_div                      dv_c [3][DIV_CELLS+1];
    logic [30:0]               q_end [3];
    logic [30:0]               q_br [3];

    logic [63:0]               zu;
    logic [63:0]               r_z1;
    logic [63:0]               r_z2;
    logic signed [63:0]        zs;
    logic                      r_zero [S_TH+1:S_BR];
    logic                      r_flip [S_TH+3:S_BR];
    t_rot                      rot_c [CORDIC_STEPS+1];
    t_rot                      rot_br;

    t_mx_in                    mx_in;
    logic signed [ENTRY_W-1:0] mx_out [9];

    logic                      r_skid_vld;
    logic signed [ENTRY_W-1:0] r_skid_m [9];
    t_side                     r_skid_side;
    logic signed [ENTRY_W-1:0] m_sel [9];
    t_side                     side_sel;

    // The cells only move when the skid entry is free, and the input is ready
    // only then, so the input holds while a finished beat waits in that entry.
    assign en           = !r_skid_vld;
    assign i_pose.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 1; s <= LAT; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (en) begin
            r_vld[1] <= i_pose.valid;
            for (int s = 2; s <= LAT; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    // Magnitudes of the rotation vector components and their squares.
    assign rv[0] = i_pose.rotvec_x;
    assign rv[1] = i_pose.rotvec_y;
    assign rv[2] = i_pose.rotvec_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            neg_in[i] = rv[i][ROT_W-1];
            mag_in[i] = neg_in[i] ? 32'(-rv[i]) : 32'(rv[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= 64'(mag_in[i]) * 64'(mag_in[i]);
            end
            r_sum        <= r_sq[0] + r_sq[1] + r_sq[2];
            r_side[1]    <= '{x: i_pose.pos_x, y: i_pose.pos_y, z: i_pose.pos_z,
                              neg: neg_in};
            r_mag[1]     <= mag_in;
            for (int s = 2; s <= LAT; s++) begin
                r_side[s] <= r_side[s-1];
            end
            for (int s = 2; s <= S_TH; s++) begin
                r_mag[s] <= r_mag[s-1];
            end
        end
    end

    // Square root: one root bit per cell.
    assign sq_c[0] = '{rem: '0, root: '0, rad: r_sum};

    for (genvar j = 0; j < SQRT_CELLS; j++) begin : g_sqrt
        rodr_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (en),
            .i_d   (sq_c[j]),
            .o_d   (sq_c[j+1])
        );
    end

    assign theta = sq_c[SQRT_CELLS].root;

    // Axis: |v_i| * 2^30 / theta, one quotient bit per cell. Since each
    // magnitude is at most theta, the remainder starts as the magnitude.
    for (genvar i = 0; i < 3; i++) begin : g_axis
        assign dv_c[i][0] = '{rem: {1'b0, r_mag[S_TH][i]}, dvsr: theta, quo: '0};

        for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
            rodr_div_cell u_cell (
                .i_clk (i_clk),
                .i_en  (en),
                .i_d   (dv_c[i][j]),
                .o_d   (dv_c[i][j+1])
            );
        end

        assign q_end[i] = dv_c[i][DIV_CELLS].quo;
    end

    if (DIV_PAD > 0) begin : g_qpad
        logic [30:0] r_qd [DIV_PAD][3];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_qd[0] <= q_end;
                for (int p = 1; p < DIV_PAD; p++) begin
                    r_qd[p] <= r_qd[p-1];
                end
            end
        end

        assign q_br = r_qd[DIV_PAD-1];
    end else begin : g_qdirect
        assign q_br = q_end;
    end

    // Angle: theta in Q.60 is below three turns, so two conditional
    // subtractions finish the reduction modulo 2*pi.
    assign zu = {theta, 32'd0};
    assign zs = signed'(r_z2);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_z1 <= (zu >= FOUR_PI60U) ? (zu - FOUR_PI60U) : zu;
            r_z2 <= (r_z1 >= unsigned'(TWO_PI60)) ? (r_z1 - unsigned'(TWO_PI60)) : r_z1;
            r_zero[S_TH+1] <= (theta == '0);
            for (int s = S_TH + 2; s <= S_BR; s++) begin
                r_zero[s] <= r_zero[s-1];
            end
            // Fold into [-pi/2, pi/2]; the middle half-turn negates both
            // sine and cosine at the end.
            if (zs > PI_HALF3) begin
                rot_c[0]       <= '{x: INV_GAIN, y: '0, z: zs - TWO_PI60};
                r_flip[S_TH+3] <= 1'b0;
            end else if (zs > HALF_PI60) begin
                rot_c[0]       <= '{x: INV_GAIN, y: '0, z: zs - PI60};
                r_flip[S_TH+3] <= 1'b1;
            end else begin
                rot_c[0]       <= '{x: INV_GAIN, y: '0, z: zs};
                r_flip[S_TH+3] <= 1'b0;
            end
            for (int s = S_TH + 4; s <= S_BR; s++) begin
                r_flip[s] <= r_flip[s-1];
            end
        end
    end

    for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_rot
        rodr_cordic_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (en),
            .i_step (STEP_W'(j)),
            .i_d    (rot_c[j]),
            .o_d    (rot_c[j+1])
        );
    end

    if (ANG_PAD > 0) begin : g_apad
        t_rot r_rd [ANG_PAD];

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_rd[0] <= rot_c[CORDIC_STEPS];
                for (int p = 1; p < ANG_PAD; p++) begin
                    r_rd[p] <= r_rd[p-1];
                end
            end
        end

        assign rot_br = r_rd[ANG_PAD-1];
    end else begin : g_adirect
        assign rot_br = rot_c[CORDIC_STEPS];
    end

    // Matrix assembly.
    assign mx_in = '{neg: r_side[S_BR].neg, flip: r_flip[S_BR], zero: r_zero[S_BR],
                     q0: q_br[0], q1: q_br[1], q2: q_br[2], x: rot_br.x, y: rot_br.y};

    rodr_matrix u_matrix (
        .i_clk (i_clk),
        .i_en  (en),
        .i_d   (mx_in),
        .o_m   (mx_out)
    );

    // Output skid entry: catches the tail beat when the sink stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_vld <= 1'b0;
        end else if (r_skid_vld) begin
            if (o_xform.ready) begin
                r_skid_vld <= 1'b0;
            end
        end else if (r_vld[LAT] && !o_xform.ready) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_vld) begin
            r_skid_m    <= mx_out;
            r_skid_side <= r_side[LAT];
        end
    end

    assign m_sel    = r_skid_vld ? r_skid_m : mx_out;
    assign side_sel = r_skid_vld ? r_skid_side : r_side[LAT];

    assign o_xform.valid = r_skid_vld || r_vld[LAT];
    assign o_xform.m00   = m_sel[0];
    assign o_xform.m01   = m_sel[1];
    assign o_xform.m02   = m_sel[2];
    assign o_xform.m10   = m_sel[3];
    assign o_xform.m11   = m_sel[4];
    assign o_xform.m12   = m_sel[5];
    assign o_xform.m20   = m_sel[6];
    assign o_xform.m21   = m_sel[7];
    assign o_xform.m22   = m_sel[8];
    assign o_xform.out_x = side_sel.x;
    assign o_xform.out_y = side_sel.y;
    assign o_xform.out_z = side_sel.z;

    `RODR_ASSERT(a_accept_enters, (i_pose.valid && i_pose.ready) |=> r_vld[1])
    `RODR_ASSERT(a_skid_catches, (r_vld[LAT] && !r_skid_vld && !o_xform.ready) |=> r_skid_vld)
    `RODR_ASSERT(a_tail_holds, (r_skid_vld && !o_xform.ready) |=> $stable(r_vld[LAT]))
    `RODR_ASSERT(a_diag_range, o_xform.valid |-> (o_xform.m00 <= ONE30 && o_xform.m00 >= -ONE30))

endmodule

// ===== test/tb_pose_scoreboard.sv =====
// Predicts the rigid transform for each accepted pose and checks result beats in order.
class pose_scoreboard;
    typedef struct {
        logic signed [31:0] m [9];
        logic signed [31:0] t [3];
    } t_xform;

    t_xform pending_xforms[$];
    int     mismatches;
    logic signed [63:0] atan_tab [28];
    logic signed [63:0] gain_inv;

    localparam logic signed [63:0] P_ONE60 = 64'sd1 <<< 60;
    localparam logic signed [63:0] P_PI    = 64'sh3243F6A8885A308D;
    localparam logic signed [63:0] P_HALF  = P_PI >>> 1;
    localparam logic signed [63:0] P_TWO   = P_PI <<< 1;
    localparam logic signed [63:0] P_ONE30 = 64'sd1 <<< 30;

    function new();
        logic signed [63:0] x, y, nx, ny, sum, term;
        logic [63:0] r, q, g;
        mismatches = 0;
        atan_tab[0] = P_PI >>> 2;
        for (int i = 1; i < 28; i++) begin
            sum = 0;
            for (int k = 0; i * (2 * k + 1) <= 60; k++) begin
                term = signed'(((64'd1 << 60) >> (i * (2 * k + 1))) / 64'(2 * k + 1));
                sum = k[0] ? sum - term : sum + term;
            end
            atan_tab[i] = sum;
        end
        x = P_ONE60;
        y = 0;
        for (int i = 0; i < 28; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i);
                ny = y - (x >>> i);
            end else begin
                nx = x - (y >>> i);
                ny = y + (x >>> i);
            end
            x = nx;
            y = ny;
        end
        g = unsigned'(x);
        r = 64'd1 << 60;
        q = 0;
        for (int i = 0; i < 60; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= g) begin
                r = r - g;
                q[0] = 1'b1;
            end
        end
        gain_inv = signed'(q);
    endfunction

    function logic signed [63:0] round_q30(logic signed [63:0] v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    function logic signed [63:0] sat_q30(logic signed [63:0] v);
        if (v > P_ONE30) return P_ONE30;
        if (v < -P_ONE30) return -P_ONE30;
        return v;
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b = b >> 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function void note_pose(logic signed [31:0] pos [3], logic signed [31:0] rv [3]);
        t_xform e;
        logic signed [63:0] v [3], k [3], x, y, z, nx, ny, c30, s30, t30, acc, a;
        logic [63:0] mag [3], sumsq, theta;
        logic [127:0] wide;
        bit flip;
        sumsq = 0;
        flip = 0;
        for (int i = 0; i < 3; i++) begin
            v[i] = 64'(rv[i]);
            mag[i] = v[i] < 0 ? unsigned'(-v[i]) : unsigned'(v[i]);
            sumsq += mag[i] * mag[i];
        end
        theta = int_sqrt(sumsq);
        if (theta == 0) begin
            for (int i = 0; i < 9; i++) e.m[i] = (i % 4 == 0) ? 32'sh4000_0000 : 32'sd0;
        end else begin
            for (int i = 0; i < 3; i++) begin
                a = signed'((mag[i] << 30) / theta);
                k[i] = v[i] < 0 ? -a : a;
            end
            wide = {64'd0, theta} << 32;
            z = signed'(64'(wide % 128'(unsigned'(P_TWO))));
            if (z > P_PI + P_HALF) z -= P_TWO;
            else if (z > P_HALF) begin
                z -= P_PI;
                flip = 1;
            end
            x = gain_inv;
            y = 0;
            for (int i = 0; i < 28; i++) begin
                if (z >= 0) begin
                    nx = x - (y >>> i);
                    ny = y + (x >>> i);
                    z -= atan_tab[i];
                end else begin
                    nx = x + (y >>> i);
                    ny = y - (x >>> i);
                    z += atan_tab[i];
                end
                x = nx;
                y = ny;
            end
            if (flip) begin
                x = -x;
                y = -y;
            end
            c30 = sat_q30(round_q30(x));
            s30 = sat_q30(round_q30(y));
            t30 = P_ONE30 - c30;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    acc = round_q30(k[i] * k[j]) * t30;
                    if (i == j) acc += c30 * P_ONE30;
                    else if ((j + 3 - i) % 3 == 1) acc -= s30 * k[3 - i - j];
                    else acc += s30 * k[3 - i - j];
                    e.m[i * 3 + j] = 32'(sat_q30(round_q30(acc)));
                end
            end
        end
        e.t = pos;
        pending_xforms.push_back(e);
    endfunction

    function void check_xform(logic signed [31:0] m [9], logic signed [31:0] t [3]);
        t_xform e;
        string names [12] = '{"m00", "m01", "m02", "m10", "m11", "m12",
                              "m20", "m21", "m22", "out_x", "out_y", "out_z"};
        if (pending_xforms.size() == 0) begin
            $error("result beat with no pose pending");
            mismatches++;
            return;
        end
        e = pending_xforms.pop_front();
        for (int i = 0; i < 12; i++) begin
            if ((i < 9 ? m[i] : t[i - 9]) !== (i < 9 ? e.m[i] : e.t[i - 9])) begin
                $error("%s expected %0d actual %0d", names[i],
                       i < 9 ? e.m[i] : e.t[i - 9], i < 9 ? m[i] : t[i - 9]);
                mismatches++;
            end
        end
    endfunction
endclass

// ===== test/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 69;
    localparam int RANDOM_POSES = 1300;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    rodr_in_if  pose_if ();
    rodr_out_if xform_if ();

    pose_to_homogeneous_transform dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pose  (pose_if.sink),
        .o_xform (xform_if.source)
    );

    pose_scoreboard xform_board = new();
    bit  stim_done = 0;
    bit  stall_long = 0;
    int  cycles = 0;

    initial begin
        pose_if.valid <= 1'b0;
        pose_if.pos_x <= '0;
        pose_if.pos_y <= '0;
        pose_if.pos_z <= '0;
        pose_if.rotvec_x <= '0;
        pose_if.rotvec_y <= '0;
        pose_if.rotvec_z <= '0;
        xform_if.ready <= 1'b0;
    end

    // Mostly short gaps, occasionally a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 80);
    endfunction

    // Mix of rotation vector shapes: tiny, moderate, full range.
    function automatic logic signed [31:0] rand_rot();
        case ($urandom_range(0, 4))
            0: return $signed($urandom_range(0, 64)) - 32;
            1, 2: return $signed($urandom_range(0, 32'h3000_0000)) - 32'sh1800_0000;
            default: return $urandom();
        endcase
    endfunction

    // Offers one pose and holds it until the block takes it. Valid stays high
    // after the accepting edge and drops only when an idle gap follows.
    task automatic send_pose(logic signed [31:0] px, py, pz, rx, ry, rz);
        int idle;
        idle = gap_len();
        if (idle != 0) begin
            pose_if.valid <= 1'b0;
            repeat (idle) @(posedge i_clk);
        end
        pose_if.valid <= 1'b1;
        pose_if.pos_x <= px;
        pose_if.pos_y <= py;
        pose_if.pos_z <= pz;
        pose_if.rotvec_x <= rx;
        pose_if.rotvec_y <= ry;
        pose_if.rotvec_z <= rz;
        @(posedge i_clk);
        while (!pose_if.ready) @(posedge i_clk);
        // Record the beat at the edge that accepted it.
        xform_board.note_pose('{px, py, pz}, '{rx, ry, rz});
    endtask

    localparam logic signed [31:0] MAXP = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] MINN = 32'sh8000_0000;
    localparam logic signed [31:0] PI28 = 32'sh3243_F6A9;

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Directed poses: zero vector gives the identity, axis-aligned turns, angles
        // near pi and 2*pi, the extremes of every field but pos_z and the largest norms.
        send_pose(0, 0, 0, 0, 0, 0);
        send_pose(MAXP, MINN, -1, 0, 0, 0);
        send_pose(MINN, MAXP, 1, 1, 0, 0);
        send_pose(1, 2, 3, 0, -1, 0);
        send_pose(-5, 7, 9, 0, 0, MAXP);
        send_pose(5, 5, 5, MINN, 0, 0);
        send_pose(0, 0, 0, MAXP, MAXP, MAXP);
        send_pose(0, 0, 0, MINN, MINN, MINN);
        send_pose(0, 0, 0, MAXP, MINN, MAXP);
        send_pose(42, 0, 0, PI28, 0, 0);
        send_pose(0, 42, 0, 0, PI28 >>> 1, 0);
        send_pose(0, 0, 42, 0, 0, -(PI28 >>> 1));
        send_pose(0, 0, 0, PI28 <<< 1, 0, 0);
        send_pose(0, 0, 0, 32'sh2000_0000, 32'sh2000_0000, 0);
        send_pose(-1, -1, -1, 32'sh1000_0000, -32'sh0800_0000, 32'sh0400_0000);
        send_pose(0, 0, 0, 32'sh4B65_F5AA, 0, 0);
        send_pose(0, 0, 0, 0, 3, -4);
        // Random poses; a long receiver hold-off runs in the middle.
        for (int n = 0; n < RANDOM_POSES; n++) begin
            if (n == 400) stall_long = 1;
            send_pose($urandom(), $urandom(), $urandom(), rand_rot(), rand_rot(), rand_rot());
        end
        pose_if.valid <= 1'b0;
        stim_done = 1;
    end

    // Result side: random back pressure, plus one long hold-off counted in cycles.
    initial begin
        int hold;
        @(posedge i_rst_n);
        forever begin
            if (stall_long) begin
                stall_long = 0;
                xform_if.ready <= 1'b0;
                hold = 0;
                while (hold < 300) begin
                    @(posedge i_clk);
                    hold++;
                end
            end
            hold = gap_len();
            xform_if.ready <= (hold == 0);
            @(posedge i_clk);
            repeat (hold) @(posedge i_clk);
            if (hold != 0) begin
                xform_if.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Result beats are sampled at the edge where valid and ready meet.
    always @(posedge i_clk) begin
        if (i_rst_n && xform_if.valid && xform_if.ready) begin
            xform_board.check_xform('{xform_if.m00, xform_if.m01, xform_if.m02,
                                     xform_if.m10, xform_if.m11, xform_if.m12,
                                     xform_if.m20, xform_if.m21, xform_if.m22},
                                    '{xform_if.out_x, xform_if.out_y, xform_if.out_z});
        end
    end

    // Watchdog and end of run.
    initial begin
        while (!(stim_done && xform_board.pending_xforms.size() == 0)
               && cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
        end else begin
            repeat (2 * LATENCY) @(posedge i_clk);
            if (xform_board.mismatches == 0 && xform_board.pending_xforms.size() == 0) begin
                $display("Regression PASS");
            end else begin
                $display("Regression FAIL");
            end
        end
        $finish;
    end
endmodule
